// File: design/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg: shared definitions of the nearest palette color map
// Types and constants used by more than one file, and helper functions.
// ----------------------------------------------------------------------------
package pnc_pkg;

  localparam int PALETTE_ENTRIES_DEFAULT = 256;

  localparam int IDX_W  = 8;
  localparam int CH_W   = 8;
  localparam int RGB_W  = 3 * CH_W;
  localparam int SQ_W   = 2 * CH_W;
  localparam int DIST_W = SQ_W + 2;
  localparam int C555_W = 15;
  localparam int ALPHA_W = 8;
  localparam int PACK_W = RGB_W + ALPHA_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [IDX_W-1:0]   TRANSPARENT_ENTRY = 8'd255;
  localparam logic [ALPHA_W-1:0] OPAQUE_ALPHA      = 8'hFF;
  localparam logic [ALPHA_W-1:0] CLEAR_ALPHA       = 8'h00;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Each 5-bit channel becomes (c << 3) + 4.
  function automatic logic [RGB_W-1:0] expand_555(input logic [C555_W-1:0] c);
    expand_555 = {c[14:10], 3'b100, c[9:5], 3'b100, c[4:0], 3'b100};
  endfunction

endpackage

// File: design/pnc_if.sv
// ----------------------------------------------------------------------------
// pnc_if: request and response channels of the nearest palette color map
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pnc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  entry_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [14:0] color_555;

  modport source (output valid, operation, entry_index, red, green, blue, color_555,
                  input ready);
  modport sink (input valid, operation, entry_index, red, green, blue, color_555,
                output ready);
endinterface

interface pnc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_color;
  logic [7:0]  nearest_index;

  modport source (output valid, packed_color, nearest_index, input ready);
  modport sink (input valid, packed_color, nearest_index, output ready);
endinterface

// File: design/palette_nearest_color_map.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_map: nearest palette color lookup
// Holds an RGB palette, packs loaded entries and finds the closest entry.
// ----------------------------------------------------------------------------
// A load request writes one palette entry and is answered in the next cycle with
// its packed word; entry 255 gets alpha zero. During a lookup the palette RAM
// read port feeds the shared distance unit one entry per cycle, and a compare
// stage keeps the lowest index of least squared distance. No request is taken
// during a lookup scan.
// Lookups should only be issued after every palette entry has been loaded.
module palette_nearest_color_map #(
  parameter int PALETTE_ENTRIES = pnc_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  pnc_req_if.sink   req,
  pnc_rsp_if.source rsp
);

  localparam int AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNT_W = AW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [CNT_W-1:0] cnt;
  logic [pnc_pkg::RGB_W-1:0] target;
  logic have;
  logic [pnc_pkg::DIST_W-1:0] best_dist;
  logic [pnc_pkg::IDX_W-1:0] best_idx;

  logic out_valid;
  logic [pnc_pkg::PACK_W-1:0] out_packed;
  logic [pnc_pkg::IDX_W-1:0] out_index;

  logic accept, out_free, out_set, issue, we;
  logic [pnc_pkg::RGB_W-1:0] rdata;
  logic [pnc_pkg::ALPHA_W-1:0] alpha;
  pnc_pkg::tag_t tag_rd, tag_dist;
  logic [pnc_pkg::DIST_W-1:0] distance;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign out_set   = (accept && (req.operation == pnc_pkg::OP_LOAD)) ||
                     ((state == ST_DONE) && out_free);
  assign issue     = (state == ST_SCAN) && (cnt < CNT_W'(PALETTE_ENTRIES));
  assign we        = accept && (req.operation == pnc_pkg::OP_LOAD) &&
                     ({1'b0, req.entry_index} < 9'(PALETTE_ENTRIES));
  assign alpha     = (req.entry_index == pnc_pkg::TRANSPARENT_ENTRY) ?
                     pnc_pkg::CLEAR_ALPHA : pnc_pkg::OPAQUE_ALPHA;

  pnc_ram #(
    .WIDTH (pnc_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (req.entry_index[AW-1:0]),
    .wdata ({req.blue, req.green, req.red}),
    .raddr (cnt[AW-1:0]),
    .rdata (rdata)
  );

  pnc_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .tag_in   (tag_rd),
    .entry    (rdata),
    .target   (target),
    .tag_out  (tag_dist),
    .distance (distance)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd.valid <= 1'b0;
    end else begin
      tag_rd.valid <= issue;
    end
    tag_rd.last <= (cnt == CNT_W'(PALETTE_ENTRIES - 1));
    tag_rd.idx  <= pnc_pkg::IDX_W'(cnt[AW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      have      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && rsp.ready && !out_set) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.operation == pnc_pkg::OP_LOAD) begin
              out_valid  <= 1'b1;
              out_packed <= {alpha, req.blue, req.green, req.red};
              out_index  <= '0;
            end else begin
              state  <= ST_SCAN;
              cnt    <= '0;
              have   <= 1'b0;
              target <= pnc_pkg::expand_555(req.color_555);
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (tag_dist.valid) begin
            if (!have || distance < best_dist) begin
              have      <= 1'b1;
              best_dist <= distance;
              best_idx  <= tag_dist.idx;
            end
            if (tag_dist.last) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_packed <= '0;
            out_index  <= best_idx;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.packed_color  = out_packed;
  assign rsp.nearest_index = out_index;

  a_no_req_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_DONE) |-> !req.ready)
    else $error("request taken during a lookup");

  a_lookup_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == pnc_pkg::OP_LOOKUP) |=> (state == ST_SCAN))
    else $error("lookup did not start a scan");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ({1'b0, rsp.nearest_index} < 9'(PALETTE_ENTRIES)))
    else $error("nearest index beyond palette");

  a_one_field_used: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.nearest_index != '0) |-> (rsp.packed_color == '0))
    else $error("lookup response carries a packed word");

endmodule

// File: design/pnc_ram.sv
// ----------------------------------------------------------------------------
// pnc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pnc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/pnc_dist.sv
// ----------------------------------------------------------------------------
// pnc_dist: squared RGB distance unit
// Registers the three channel squares and sums them for the compare stage.
// ----------------------------------------------------------------------------
module pnc_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  pnc_pkg::tag_t                tag_in,
  input  logic [pnc_pkg::RGB_W-1:0]    entry,
  input  logic [pnc_pkg::RGB_W-1:0]    target,
  output pnc_pkg::tag_t                tag_out,
  output logic [pnc_pkg::DIST_W-1:0]   distance
);

  logic [pnc_pkg::CH_W-1:0] d_r, d_g, d_b;
  logic [pnc_pkg::SQ_W-1:0] sq_r, sq_g, sq_b;

  assign d_r = pnc_pkg::abs_diff(entry[7:0], target[7:0]);
  assign d_g = pnc_pkg::abs_diff(entry[15:8], target[15:8]);
  assign d_b = pnc_pkg::abs_diff(entry[23:16], target[23:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else begin
      tag_out.valid <= tag_in.valid;
    end
    tag_out.last <= tag_in.last;
    tag_out.idx  <= tag_in.idx;
    sq_r <= d_r * d_r;
    sq_g <= d_g * d_g;
    sq_b <= d_b * d_b;
  end

  assign distance = pnc_pkg::DIST_W'(sq_r) + pnc_pkg::DIST_W'(sq_g) +
                    pnc_pkg::DIST_W'(sq_b);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of palette_nearest_color_map
// Fills the whole palette and then sends directed and random load and lookup
// requests under changing idle and stall patterns. A mirror of the palette
// predicts each answer, and answers are checked in order as they arrive.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PER_PHASE = 420;

  typedef struct {
    logic [pnc_pkg::PACK_W-1:0] packed_color;
    logic [pnc_pkg::IDX_W-1:0]  nearest_index;
  } answer_t;

  class palette_mirror;
    logic [pnc_pkg::RGB_W-1:0] palette_rgb [256];
    answer_t                   expected_answers [$];
    int                        failures = 0;

    function logic [pnc_pkg::IDX_W-1:0] closest_entry(logic [pnc_pkg::C555_W-1:0] c555);
      int                        target [3];
      int                        distance;
      int                        best_dist;
      int                        d;
      logic [pnc_pkg::IDX_W-1:0] best;
      target[0] = {c555[4:0], 3'b100};
      target[1] = {c555[9:5], 3'b100};
      target[2] = {c555[14:10], 3'b100};
      best = '0;
      best_dist = 0;
      for (int e = 0; e < 256; e++) begin
        distance = 0;
        for (int ch = 0; ch < 3; ch++) begin
          d = target[ch] - int'(palette_rgb[e][ch*pnc_pkg::CH_W +: pnc_pkg::CH_W]);
          distance += d * d;
        end
        if (e == 0 || distance < best_dist) begin
          best = pnc_pkg::IDX_W'(e);
          best_dist = distance;
        end
      end
      return best;
    endfunction

    function void note_request(logic op, logic [pnc_pkg::IDX_W-1:0] idx,
                               logic [pnc_pkg::CH_W-1:0] r,
                               logic [pnc_pkg::CH_W-1:0] g,
                               logic [pnc_pkg::CH_W-1:0] b,
                               logic [pnc_pkg::C555_W-1:0] c555);
      answer_t a;
      if (op == pnc_pkg::OP_LOAD) begin
        palette_rgb[idx] = {b, g, r};
        a.packed_color = {(idx == pnc_pkg::TRANSPARENT_ENTRY) ?
                          pnc_pkg::CLEAR_ALPHA : pnc_pkg::OPAQUE_ALPHA, b, g, r};
        a.nearest_index = '0;
      end else begin
        a.packed_color = '0;
        a.nearest_index = closest_entry(c555);
      end
      expected_answers.push_back(a);
    endfunction

    function void check_answer(logic [pnc_pkg::PACK_W-1:0] packed_color,
                               logic [pnc_pkg::IDX_W-1:0] nearest_index);
      answer_t a;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: packed_color %h nearest_index %0d",
               packed_color, nearest_index);
        failures++;
        return;
      end
      a = expected_answers.pop_front();
      if (packed_color !== a.packed_color) begin
        $error("packed_color: expected %h, actual %h", a.packed_color, packed_color);
        failures++;
      end
      if (nearest_index !== a.nearest_index) begin
        $error("nearest_index: expected %0d, actual %0d", a.nearest_index, nearest_index);
        failures++;
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  int            sender_idle_pct = 0;
  int            receiver_stall_pct = 0;
  int unsigned   cycle_count = 0;
  palette_mirror mirror = new();

  pnc_req_if req();
  pnc_rsp_if rsp();

  palette_nearest_color_map i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      mirror.check_answer(rsp.packed_color, rsp.nearest_index);
    end
  end

  // Called and returning at a falling edge.
  task automatic send_request(input logic op, input logic [pnc_pkg::IDX_W-1:0] idx,
                              input logic [pnc_pkg::CH_W-1:0] r,
                              input logic [pnc_pkg::CH_W-1:0] g,
                              input logic [pnc_pkg::CH_W-1:0] b,
                              input logic [pnc_pkg::C555_W-1:0] c555);
    while ($urandom_range(99) < sender_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.entry_index <= idx;
    req.red <= r;
    req.green <= g;
    req.blue <= b;
    req.color_555 <= c555;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    mirror.note_request(op, idx, r, g, b, c555);
    @(negedge clk);
  endtask

  task automatic send_load(input logic [pnc_pkg::IDX_W-1:0] idx,
                           input logic [pnc_pkg::CH_W-1:0] r,
                           input logic [pnc_pkg::CH_W-1:0] g,
                           input logic [pnc_pkg::CH_W-1:0] b);
    send_request(pnc_pkg::OP_LOAD, idx, r, g, b,
                 pnc_pkg::C555_W'($urandom_range(32767)));
  endtask

  task automatic send_lookup(input logic [pnc_pkg::C555_W-1:0] c555);
    send_request(pnc_pkg::OP_LOOKUP, pnc_pkg::IDX_W'($urandom_range(255)),
                 pnc_pkg::CH_W'($urandom_range(255)), pnc_pkg::CH_W'($urandom_range(255)),
                 pnc_pkg::CH_W'($urandom_range(255)), c555);
  endtask

  initial begin
    logic [pnc_pkg::IDX_W-1:0]  idx;
    logic [pnc_pkg::RGB_W-1:0]  rgb;
    logic [pnc_pkg::C555_W-1:0] c555;

    req.valid = 1'b0;
    req.operation = pnc_pkg::OP_LOAD;
    req.entry_index = '0;
    req.red = '0;
    req.green = '0;
    req.blue = '0;
    req.color_555 = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Every entry is written before the first lookup.
    for (int i = 0; i < 256; i++) begin
      send_load(pnc_pkg::IDX_W'(i), pnc_pkg::CH_W'($urandom_range(255)),
                pnc_pkg::CH_W'($urandom_range(255)), pnc_pkg::CH_W'($urandom_range(255)));
    end

    send_load(pnc_pkg::TRANSPARENT_ENTRY, 8'hFF, 8'hFF, 8'hFF);
    send_load(8'd0, 8'h00, 8'h00, 8'h00);
    send_load(8'd10, 8'd100, 8'd100, 8'd100);
    send_load(8'd200, 8'd100, 8'd100, 8'd100);
    send_lookup({5'd12, 5'd12, 5'd12});
    send_lookup(15'h0000);
    send_lookup(15'h7FFF);
    send_lookup(15'h001F);
    send_lookup(15'h03E0);
    send_lookup(15'h7C00);
    send_load(8'd254, 8'hFF, 8'h00, 8'h00);
    send_load(8'd1, 8'h00, 8'hFF, 8'h00);
    send_load(8'd2, 8'h00, 8'h00, 8'hFF);
    send_lookup(15'h001F);
    send_lookup(15'h03E0);
    send_lookup(15'h7C00);
    // Black at the transparent entry ties with entry zero.
    send_load(pnc_pkg::TRANSPARENT_ENTRY, 8'h00, 8'h00, 8'h00);
    send_lookup(15'h0000);
    send_request(pnc_pkg::OP_LOOKUP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 15'h4210);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
        default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(99) < 40) begin
          if ($urandom_range(1) == 0) begin
            c555 = pnc_pkg::C555_W'($urandom_range(32767));
          end else begin
            rgb = mirror.palette_rgb[pnc_pkg::IDX_W'($urandom_range(255))];
            c555 = {rgb[23:19], rgb[15:11], rgb[7:3]};
          end
          send_lookup(c555);
        end else begin
          idx = ($urandom_range(9) == 0) ? pnc_pkg::TRANSPARENT_ENTRY :
                pnc_pkg::IDX_W'($urandom_range(255));
          case ($urandom_range(9))
            0, 1: rgb = mirror.palette_rgb[pnc_pkg::IDX_W'($urandom_range(255))];
            2: rgb = {{pnc_pkg::CH_W{1'($urandom_range(1))}},
                      {pnc_pkg::CH_W{1'($urandom_range(1))}},
                      {pnc_pkg::CH_W{1'($urandom_range(1))}}};
            default: rgb = pnc_pkg::RGB_W'($urandom_range(24'hFFFFFF));
          endcase
          send_load(idx, rgb[7:0], rgb[15:8], rgb[23:16]);
        end
      end
    end

    req.valid <= 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    while (mirror.expected_answers.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mirror.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
